### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and controller/datapath interface types of the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned ROWS_DEF = 25;
  localparam int unsigned COLS_DEF = 80;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned CELL_W = CHAR_W + ATTR_W;

  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0a;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h0f;

  // controller -> datapath
  typedef struct packed {
    logic latch;      // capture request fields
    logic cnt_clr;    // zero the sweep counter
    logic home;       // cursor and top-row base to zero
    logic clr_step;   // write a zero cell at the counter, count up
    logic fill_step;  // write a blank in the recycled row, count up
    logic scroll;     // advance top-row base, cursor to last row
    logic put_write;  // write character at cursor, advance cursor
    logic newline;    // cursor to start of next row, saturating
    logic respond;    // load result registers and strobe
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              is_newline;
    logic              at_end;
    logic              clr_last;
    logic              fill_last;
  } status_t;

endpackage

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the console: decode, clear sweep, scroll fill, put, respond.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_DEC  = 7'b0000100,
    S_FILL = 7'b0001000,
    S_PUT  = 7'b0010000,
    S_CLR  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        priority if (status_i.func == tcw_pkg::FUNC_PUT) begin
          if (status_i.is_newline) begin
            cmd_o.newline = 1'b1;
            state_d       = S_RESP;
          end else if (status_i.at_end) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_FILL;
          end else begin
            cmd_o.put_write = 1'b1;
            state_d         = S_RESP;
          end
        end else if (status_i.func == tcw_pkg::FUNC_CLEAR) begin
          cmd_o.cnt_clr = 1'b1;
          cmd_o.home    = 1'b1;
          state_d       = S_CLR;
        end else begin
          // read: RAM output is valid in the response cycle
          state_d = S_RESP;
        end
      end
      S_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.fill_last) begin
          cmd_o.scroll = 1'b1;
          state_d      = S_PUT;
        end
      end
      S_PUT: begin
        cmd_o.put_write = 1'b1;
        state_d         = S_RESP;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

### rtl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Console datapath: cell store with circular row base, cursor, results.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = tcw_pkg::COLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::cmd_t                cmd_i,
  output tcw_pkg::status_t             status_o,
  input  logic [tcw_pkg::FUNC_W-1:0]   func_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]    cell_index_i,
  input  logic                         cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data_i,
  output logic                         done_o,
  output logic [tcw_pkg::POS_W-1:0]    cursor_pos_o,
  output logic                         scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0]   read_char_o,
  output logic [tcw_pkg::ATTR_W-1:0]   read_attr_o
);

  localparam int unsigned CELLS  = ROWS * COLS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned OFF_W  = $clog2(CELLS + 1);
  localparam int unsigned COL_W  = $clog2(COLS);
  localparam int unsigned PHYS_W = ADDR_W + 1;
  localparam int unsigned NXT_W  = $clog2(CELLS + COLS + 1);

  // request fields
  logic [tcw_pkg::FUNC_W-1:0] func_q;
  logic [tcw_pkg::CHAR_W-1:0] char_q;
  logic [tcw_pkg::IDX_W-1:0]  idx_q;

  logic [tcw_pkg::ATTR_W-1:0] attr_q;

  // cursor offset, its column, and the physical base of the top row
  logic [OFF_W-1:0]  cur_q, cur_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ADDR_W-1:0] top_q, top_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              scr_q, scr_d;

  logic                       done_q;
  logic [tcw_pkg::POS_W-1:0]  pos_q;
  logic                       scr_out_q;
  logic [tcw_pkg::CHAR_W-1:0] rchar_q;
  logic [tcw_pkg::ATTR_W-1:0] rattr_q;

  logic [PHYS_W-1:0] cur_sum, idx_sum;
  logic [ADDR_W-1:0] cur_phys, idx_phys;
  logic [NXT_W-1:0]  nl_sum;
  logic              idx_ok;

  logic                       we;
  logic [ADDR_W-1:0]          waddr;
  logic [tcw_pkg::CELL_W-1:0] wdata;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  // logical offset -> physical address, rows are stored circularly
  assign cur_sum  = {1'b0, ADDR_W'(cur_q)} + {1'b0, top_q};
  assign cur_phys = (cur_sum >= PHYS_W'(CELLS)) ? ADDR_W'(cur_sum - PHYS_W'(CELLS))
                                                : ADDR_W'(cur_sum);
  assign idx_sum  = {1'b0, ADDR_W'(idx_q)} + {1'b0, top_q};
  assign idx_phys = (idx_sum >= PHYS_W'(CELLS)) ? ADDR_W'(idx_sum - PHYS_W'(CELLS))
                                                : ADDR_W'(idx_sum);
  assign idx_ok   = (32'(idx_q) < CELLS);

  assign nl_sum = NXT_W'(cur_q) - NXT_W'(col_q) + NXT_W'(COLS);

  always_comb begin
    we    = 1'b0;
    waddr = cur_phys;
    wdata = {attr_q, char_q};
    priority if (cmd_i.clr_step) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else if (cmd_i.fill_step) begin
      we    = 1'b1;
      waddr = top_q + cnt_q;
      wdata = {attr_q, tcw_pkg::SPACE_CODE};
    end else if (cmd_i.put_write) begin
      we = 1'b1;
    end else begin
      we = 1'b0;
    end
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(idx_phys),
    .rdata_o(rdata)
  );

  always_comb begin
    cur_d = cur_q;
    col_d = col_q;
    top_d = top_q;
    cnt_d = cnt_q;
    scr_d = scr_q;
    if (cmd_i.latch) begin
      scr_d = 1'b0;
    end
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end
    if (cmd_i.clr_step || cmd_i.fill_step) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (cmd_i.home) begin
      cur_d = '0;
      col_d = '0;
      top_d = '0;
    end
    if (cmd_i.scroll) begin
      top_d = (top_q == ADDR_W'(CELLS - COLS)) ? '0 : top_q + ADDR_W'(COLS);
      cur_d = OFF_W'(CELLS - COLS);
      col_d = '0;
      scr_d = 1'b1;
    end
    if (cmd_i.put_write) begin
      cur_d = cur_q + 1'b1;
      col_d = (col_q == COL_W'(COLS - 1)) ? '0 : col_q + 1'b1;
    end
    if (cmd_i.newline) begin
      cur_d = (nl_sum > NXT_W'(CELLS)) ? OFF_W'(CELLS) : OFF_W'(nl_sum);
      col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q  <= '0;
      col_q  <= '0;
      top_q  <= '0;
      cnt_q  <= '0;
      scr_q  <= 1'b0;
      attr_q <= tcw_pkg::ATTR_RESET;
      done_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      col_q  <= col_d;
      top_q  <= top_d;
      cnt_q  <= cnt_d;
      scr_q  <= scr_d;
      done_q <= cmd_i.respond;
      if (cfg_we_i) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      char_q <= char_code_i;
      idx_q  <= cell_index_i;
    end
    if (cmd_i.respond) begin
      pos_q     <= tcw_pkg::POS_W'(cur_q);
      scr_out_q <= scr_q;
      if (func_q == tcw_pkg::FUNC_READ && idx_ok) begin
        rchar_q <= rdata[tcw_pkg::CHAR_W-1:0];
        rattr_q <= rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
      end else begin
        rchar_q <= '0;
        rattr_q <= '0;
      end
    end
  end

  assign status_o.func       = func_q;
  assign status_o.is_newline = (char_q == tcw_pkg::NEWLINE_CODE);
  assign status_o.at_end     = (cur_q >= OFF_W'(CELLS));
  assign status_o.clr_last   = (cnt_q == ADDR_W'(CELLS - 1));
  assign status_o.fill_last  = (cnt_q == ADDR_W'(COLS - 1));

  assign done_o       = done_q;
  assign cursor_pos_o = pos_q;
  assign scrolled_o   = scr_out_q;
  assign read_char_o  = rchar_q;
  assign read_attr_o  = rattr_q;

endmodule

### rtl/text_console_writer.sv
// Sequence: put, newline and read requests go through decode and response to done_o;
//   a put that scrolls first blanks the recycled row (one blanking write per column);
//   a clear sweeps the whole store (one cell write per cycle, one RAM port).
// Throughput: one request at a time; a new request is taken in the done_o cycle.
// Reset: the cell store is swept to zero, busy stays high until the sweep is done.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with scrolling, clear and cell readback.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = tcw_pkg::COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [tcw_pkg::FUNC_W-1:0] func_i,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]  cell_index_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [tcw_pkg::POS_W-1:0]  cursor_pos_o,
  output logic                       scrolled_o,
  output logic [tcw_pkg::CHAR_W-1:0] read_char_o,
  output logic [tcw_pkg::ATTR_W-1:0] read_attr_o
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .status_i(status),
    .cmd_o   (cmd)
  );

  tcw_dp #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .func_i      (func_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .cursor_pos_o(cursor_pos_o),
    .scrolled_o  (scrolled_o),
    .read_char_o (read_char_o),
    .read_attr_o (read_attr_o)
  );

endmodule

### rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the console's request/result sequencing.
// ----------------------------------------------------------------------------
module tcw_checker #(
  parameter int unsigned ROWS = tcw_pkg::ROWS_DEF,
  parameter int unsigned COLS = tcw_pkg::COLS_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start,
  input logic                      busy,
  input logic                      done_o,
  input logic [tcw_pkg::POS_W-1:0] cursor_pos_o,
  input logic                      scrolled_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam bit          FITS  = (CELLS < 2048);

  // an accepted request raises busy (the block stays busy until its result)
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but busy not raised");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && FITS |-> 32'(cursor_pos_o) <= CELLS)
    else $error("cursor beyond end of screen");

  // after a scroll the character lands at the start of the last row
  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && scrolled_o && FITS |-> 32'(cursor_pos_o) == CELLS - COLS + 1)
    else $error("cursor wrong after scroll");

endmodule

bind text_console_writer tcw_checker #(
  .ROWS(ROWS),
  .COLS(COLS)
) u_tcw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .cursor_pos_o(cursor_pos_o),
  .scrolled_o  (scrolled_o)
);
